/* hdl/positional_list_insert_delete_unit_assert.svh */
// ----------------------------------------------------------------------------
// positional list assertion macros
// concurrent assertion helpers shared by the list control logic
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define PLID_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// condition must never be seen outside reset
`define PLID_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`else
`define PLID_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define PLID_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

/* hdl/plid_pkg.sv */
// ----------------------------------------------------------------------------
// plid_pkg
// request, status and cell control types of the positional list unit
// ----------------------------------------------------------------------------
package plid_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	// wide enough for a cell index at the largest supported capacity
	localparam int IDX_W  = 6;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_SHOW   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_REJECT = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	// per-cycle action broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SHOW = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] data;
	} cell_ctl_t;

endpackage

/* hdl/plid_cell.sv */
// ----------------------------------------------------------------------------
// plid_cell
// one list slot: holds a value and takes from its neighbors on shifts
// ----------------------------------------------------------------------------
module plid_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  plid_pkg::cell_ctl_t                ctl,
	input  logic signed [plid_pkg::DATA_W-1:0] left,
	input  logic signed [plid_pkg::DATA_W-1:0] right,
	input  logic signed [plid_pkg::DATA_W-1:0] head,
	output logic signed [plid_pkg::DATA_W-1:0] val_q
);
	import plid_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [DATA_W-1:0] val_d;

	// select the next slot value from the broadcast action
	always_comb begin
		val_d = val_q;
		case (ctl.op)
			CELL_INS: begin
				if (MY_IDX > ctl.idx) val_d = left;
				else if (MY_IDX == ctl.idx) val_d = ctl.data;
			end
			CELL_DEL: begin
				if (MY_IDX >= ctl.idx) val_d = right;
			end
			CELL_ROT: begin
				if (MY_IDX < ctl.idx) val_d = right;
				else if (MY_IDX == ctl.idx) val_d = head;
			end
			default: val_d = val_q;
		endcase
	end

	// slot storage
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

/* hdl/plid_ctrl.sv */
// ----------------------------------------------------------------------------
// plid_ctrl
// request decode, entry count, show sequencer and result register
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_unit_assert.svh"

module plid_ctrl #(
	parameter int CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic [plid_pkg::POS_W-1:0]         position,
	input  logic signed [plid_pkg::DATA_W-1:0] value,
	input  logic signed [plid_pkg::DATA_W-1:0] head,
	output plid_pkg::cell_ctl_t                cell_ctl,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY+1)-1:0]      count,
	output logic signed [plid_pkg::DATA_W-1:0] element,
	output logic                               last
);
	import plid_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	ctrl_state_t              state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [IDX_W-1:0]         idx_q;
	logic                     out_valid_q;
	status_t                  out_status_q, status_d;
	logic [CNT_W-1:0]         out_count_q;
	logic signed [DATA_W-1:0] out_elem_q, elem_d;
	logic                     out_last_q, last_d;
	logic                     out_ready, accept, load_out, full, ins_bad, del_bad, show_last;
	logic [CMP_W-1:0]         count_ext, pos_ext, idx_ext;
	req_t                     req;

	// handshake and request checks
	assign req       = req_t'(req_type);
	assign out_ready = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_ready;
	assign accept    = in_valid && !in_stall;
	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position);
	assign idx_ext   = CMP_W'(idx_q);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign ins_bad   = (pos_ext == '0) || (pos_ext > count_ext + CMP_W'(1));
	assign del_bad   = (pos_ext == '0) || (pos_ext > count_ext);
	assign show_last = (idx_ext + CMP_W'(1) == count_ext);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req == REQ_SHOW && count_q != '0) state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready && show_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// cell action, count update and result payload
	always_comb begin
		cell_ctl.op   = CELL_HOLD;
		cell_ctl.idx  = '0;
		cell_ctl.data = value;
		count_d       = count_q;
		load_out      = 1'b0;
		status_d      = STAT_OK;
		elem_d        = '0;
		last_d        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (req)
						REQ_APPEND: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								cell_ctl.op  = CELL_INS;
								cell_ctl.idx = IDX_W'(count_q);
								count_d      = count_q + CNT_W'(1);
							end
						end
						REQ_INSERT: begin
							if (ins_bad) begin
								status_d = STAT_REJECT;
							end else if (full) begin
								status_d = STAT_FULL;
							end else begin
								cell_ctl.op  = CELL_INS;
								cell_ctl.idx = IDX_W'(position - POS_W'(1));
								count_d      = count_q + CNT_W'(1);
							end
						end
						REQ_DELETE: begin
							if (del_bad) begin
								status_d = STAT_REJECT;
							end else begin
								cell_ctl.op  = CELL_DEL;
								cell_ctl.idx = IDX_W'(position - POS_W'(1));
								count_d      = count_q - CNT_W'(1);
							end
						end
						REQ_SHOW: begin
							if (count_q == '0) status_d = STAT_EMPTY;
							else load_out = 1'b0;
						end
						default: status_d = STAT_REJECT;
					endcase
				end
			end
			ST_SHOW: begin
				if (out_ready) begin
					load_out     = 1'b1;
					cell_ctl.op  = CELL_ROT;
					cell_ctl.idx = IDX_W'(count_q - CNT_W'(1));
					elem_d       = head;
					last_d       = show_last;
				end
			end
			default: load_out = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_IDLE) idx_q <= '0;
			else if (out_ready) idx_q <= idx_q + IDX_W'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_d;
			out_count_q  <= count_d;
			out_elem_q   <= elem_d;
			out_last_q   <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign count     = out_count_q;
	assign element   = out_elem_q;
	assign last      = out_last_q;

	// checks
	`PLID_NEVER(a_count_cap, clk, arst_n, count_q > CNT_W'(CAPACITY), "entry count above capacity")
	`PLID_ASSERT(a_count_hold, clk, arst_n, !accept |=> $stable(count_q), "count moved without transfer")
	`PLID_ASSERT(a_show_nonempty, clk, arst_n, (state_q == ST_SHOW) |-> (count_q != '0), "show on empty list")
	`PLID_ASSERT(a_single_result, clk, arst_n, (accept && req != REQ_SHOW) |=> out_valid_q, "missing result")

endmodule

/* hdl/positional_list_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// ordered list of signed 32-bit values with append, insert, delete and show
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries req_type, position, value;
//   a transfer happens when in_valid is high and in_stall is low
//   output channel (out_valid / out_stall) carries status, count, element, last
//   append, insert and delete: one result, registered in the cycle after the
//     input transfer; a new request can follow every cycle while the output
//     is drained, so these run at one item per cycle
//   show: entry count results, the first loaded from the show state after the
//     transfer, then one per cycle while the output is drained; input stalls until the final result is issued
//   the list is a row of CAPACITY slots; the affected slots shift together;
//     show rotates the used slots past slot zero, one step per result
//   reset clears the entry count and empties the list; slot contents are
//     not cleared and are never read before written
//   while out_stall is high with a result waiting, the result register holds and nothing advances
// ----------------------------------------------------------------------------
module positional_list_insert_delete_unit #(
	parameter int CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic [plid_pkg::POS_W-1:0]         position,
	input  logic signed [plid_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY+1)-1:0]      count,
	output logic signed [plid_pkg::DATA_W-1:0] element,
	output logic                               last
);
	import plid_pkg::*;

	cell_ctl_t                cell_ctl;
	logic signed [DATA_W-1:0] slot_val [CAPACITY];

	// control and result register
	plid_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.position (position),
		.value    (value),
		.head     (slot_val[0]),
		.cell_ctl (cell_ctl),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.count    (count),
		.element  (element),
		.last     (last)
	);

	// slot chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_v, right_v;
		if (i == 0) begin : g_first
			assign left_v = cell_ctl.data;
		end else begin : g_mid_l
			assign left_v = slot_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = slot_val[i];
		end else begin : g_mid_r
			assign right_v = slot_val[i+1];
		end
		plid_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (cell_ctl),
			.left (left_v),
			.right(right_v),
			.head (slot_val[0]),
			.val_q(slot_val[i])
		);
	end

endmodule
